### sv/bf16_topk_pkg.sv
package bf16_topk_pkg;

  localparam int TOP_K_DEF      = 8;
  localparam int TILE_LANES_DEF = 32;

  localparam logic [15:0] MAG_MASK    = 16'h7FFF;
  localparam logic [15:0] SIGN_BIT    = 16'h8000;
  localparam logic [15:0] KEY_MASK    = 16'hFFFF;
  localparam logic [31:0] EMPTY_ID    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0] value_fp32;
    logic [31:0] id;
    logic [2:0]  rank;
    logic        end_of_list;
  } out_t;

  // one kept entry of the list
  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [15:0] value;
    logic [31:0] id;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   load;   // an item is accepted this cycle
    logic   shift;  // list moves one place toward rank 0
    entry_t ent;    // candidate entry of the accepted item
  } cell_ctl_t;

  function automatic logic [15:0] zero_fold(input logic [15:0] bits);
    return ((bits & MAG_MASK) != 16'h0000) ? bits : 16'h0000;
  endfunction

  // order-preserving key: negatives complement, positives get bit 15 set
  function automatic logic [15:0] order_key(input logic [15:0] bits);
    return ((bits & SIGN_BIT) != 16'h0000) ? (~bits & KEY_MASK) : (bits | SIGN_BIT);
  endfunction

endpackage

### sv/bf16_topk_cell.sv
module bf16_topk_cell
  import bf16_topk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    prev_ent,
  input  logic      prev_ins,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      ins
);

  entry_t ent_next;

  // candidate belongs at or above this slot; strict compare keeps ties stable
  assign ins = ctl.load && (!ent.valid || (ent.key < ctl.ent.key));

  always_comb begin
    ent_next = ent;
    if (ctl.shift) begin
      ent_next = next_ent;
    end else if (ins) begin
      ent_next = prev_ins ? prev_ent : ctl.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.key   <= ent_next.key;
    ent.value <= ent_next.value;
    ent.id    <= ent_next.id;
  end

endmodule

### sv/bf16_stream_top_k_select.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in_data   (in_t: value, last)
// out       out  out_valid / out_ready  out_data  (out_t: value_fp32, id, rank, end_of_list)
// cfg       in   cfg_wr_en              cfg_wr_data (start_tile)
//
// Scan: one item per cycle; each item is inserted into a chain of TOP_K cells in the cycle it
// is accepted. After the item marked last, the chain shifts out toward rank 0 one result per
// cycle while the output is not stalled, TOP_K results in all, with in_ready low until the last
// result is in the output register. Reset (rst, synchronous) empties the list, zeroes the
// position and start_tile. A stalled output holds the chain in place.
module bf16_stream_top_k_select
  import bf16_topk_pkg::*;
#(
  parameter int TOP_K      = TOP_K_DEF,
  parameter int TILE_LANES = TILE_LANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int CW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  typedef enum logic [1:0] {
    ST_SCAN  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t      state, state_next;
  logic [15:0] start_tile;
  logic [31:0] position;
  logic [CW-1:0] cnt;
  logic        in_fire;
  logic        drain_step;
  logic [15:0] folded;
  cell_ctl_t   ctl;

  entry_t ent      [TOP_K];
  entry_t prev_ent [TOP_K];
  entry_t next_ent [TOP_K];
  logic   ins      [TOP_K];
  logic   prev_ins [TOP_K];

  assign in_ready   = (state == ST_SCAN);
  assign in_fire    = in_valid && in_ready;
  assign drain_step = (state == ST_DRAIN) && (!out_valid || out_ready);

  assign folded        = zero_fold(in_data.value);
  assign ctl.load      = in_fire;
  assign ctl.shift     = drain_step;
  assign ctl.ent.valid = 1'b1;
  assign ctl.ent.key   = order_key(folded);
  assign ctl.ent.value = folded;
  assign ctl.ent.id    = 32'(start_tile) * 32'(TILE_LANES) + position;

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_ent[i] = ctl.ent;
      assign prev_ins[i] = 1'b0;
    end else begin : g_body
      assign prev_ent[i] = ent[i-1];
      assign prev_ins[i] = ins[i-1];
    end
    if (i == TOP_K - 1) begin : g_tail
      assign next_ent[i] = '0;
    end else begin : g_mid
      assign next_ent[i] = ent[i+1];
    end

    bf16_topk_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev_ent (prev_ent[i]),
      .prev_ins (prev_ins[i]),
      .next_ent (next_ent[i]),
      .ent      (ent[i]),
      .ins      (ins[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SCAN: begin
        if (in_fire && in_data.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_step && (cnt == CW'(TOP_K - 1))) state_next = ST_SCAN;
      end
      default: state_next = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SCAN;
      start_tile <= 16'h0000;
      position   <= 32'h0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) start_tile <= cfg_wr_data;
      if (in_fire) begin
        position <= in_data.last ? 32'h0 : position + 32'h1;
      end
      if (drain_step) begin
        cnt       <= (cnt == CW'(TOP_K - 1)) ? '0 : cnt + CW'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      out_data.value_fp32  <= ent[0].valid ? {ent[0].value, 16'h0000} : 32'h0;
      out_data.id          <= ent[0].valid ? ent[0].id : EMPTY_ID;
      out_data.rank        <= 3'(cnt);
      out_data.end_of_list <= (cnt == CW'(TOP_K - 1));
    end
  end

endmodule
